### src/mgam_pkg.sv
// Shared constants, codes and the alpha weight table for the memory growth monitor.
package mgam_pkg;

  localparam int CHANGE_W  = 48;
  localparam int SCORE_W   = 32;
  localparam int QUOTA_W   = 48;
  localparam int CFG_W     = 48;
  localparam int PCT_W     = 7;
  localparam int WEIGHT_W  = 17;
  localparam int WHOLE_W   = 14;
  localparam int Q_FRAC    = 16;
  localparam int CAP_BIT   = 23;
  localparam int CHG_SHIFT = 10;
  localparam int PCT_FULL  = 100;
  localparam int PCT_RESET = 50;

  localparam logic [WEIGHT_W-1:0] Q_UNIT = WEIGHT_W'(1 << Q_FRAC);
  localparam logic [WHOLE_W-1:0] WHOLE_CAP = WHOLE_W'(1 << (CAP_BIT - CHG_SHIFT));

  localparam logic [1:0] CFG_ALPHA     = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_QUOTA     = 2'd2;
  localparam logic [1:0] CFG_ACTION    = 2'd3;

  localparam logic [1:0] ACT_ALERT    = 2'd0;
  localparam logic [1:0] ACT_THROTTLE = 2'd1;
  localparam logic [1:0] ACT_KILL     = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_DETACH   = 3'd1;
  localparam logic [2:0] EV_ALERT    = 3'd2;
  localparam logic [2:0] EV_THROTTLE = 3'd3;
  localparam logic [2:0] EV_KILL     = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DETACH,
    MODE_ACTIVE
  } mode_t;

  typedef logic [WEIGHT_W-1:0] alpha_tab_t [0:(1 << PCT_W)-1];

  // percent clamped to full scale, weight = 65536 * pct / 100
  function automatic alpha_tab_t build_alpha_tab();
    alpha_tab_t tab;
    int pct;
    for (int i = 0; i < (1 << PCT_W); i++) begin
      pct = (i > PCT_FULL) ? PCT_FULL : i;
      tab[i] = WEIGHT_W'((pct << Q_FRAC) / 100);
    end
    return tab;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha_tab();

endpackage

### src/memory_growth_anomaly_monitor.sv
// Top level of the memory growth anomaly monitor.
// Input channel in_valid/in_ready carries one memory size sample per transfer.
// Output channel out_valid/out_ready returns exactly one result per sample:
// event kind, breach cause, updated Q16.16 score and absolute size change.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write it
// only while no sample is in flight.
// Each sample passes the input stage, which computes the change and the weighted
// new term, and then the output stage, which updates the score through one 17x32
// multiply in the score feedback loop.
// Throughput: one sample per cycle while the receiver does not stall.
// Reset: watching on, previous size and score zero, alpha 50 percent,
// threshold all ones, quota off, action alert.
// A zero sample gives a detach event and later samples report event none
// until reset.
// If the receiver stalls, the output register and the input stage hold and
// in_ready drops once both are full; nothing is lost or repeated.
module memory_growth_anomaly_monitor #(
  parameter int SIZE_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [mgam_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SIZE_BITS-1:0]          in_size_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_event_kind,
  output logic                          out_breach_cause,
  output logic [mgam_pkg::SCORE_W-1:0]  out_score_out,
  output logic [mgam_pkg::CHANGE_W-1:0] out_change_out
);
  import mgam_pkg::*;

  localparam int CMP_W = (SIZE_BITS > CHANGE_W) ? SIZE_BITS : CHANGE_W;
  localparam int TERM_W = WEIGHT_W + WHOLE_W;

  // configuration
  logic [WEIGHT_W-1:0] alpha_w_r;
  logic [SCORE_W-1:0]  thresh_r;
  logic [QUOTA_W-1:0]  quota_r;
  logic [1:0]          action_r;

  // monitor state
  logic                watching_r;
  logic [SIZE_BITS-1:0] last_size_r;

  // input stage
  logic                s1_v_r;
  mode_t               s1_mode_r;
  logic [CHANGE_W-1:0] s1_change_r;
  logic [SCORE_W-1:0]  s1_term_a_r;
  logic                s1_quota_hit_r;

  // output stage
  logic                out_valid_r;
  logic [2:0]          out_kind_r;
  logic                out_cause_r;
  logic [SCORE_W-1:0]  out_score_r;
  logic [CHANGE_W-1:0] out_change_r;

  logic                adv;
  logic                s1_en;
  logic                in_fire;
  logic                s1_fire;
  logic                s1_active;
  logic [CMP_W-1:0]    sample_ext;
  logic [CMP_W-1:0]    last_ext;
  logic [CMP_W-1:0]    quota_ext;
  logic [CMP_W-1:0]    diff;
  logic [WHOLE_W-1:0]  whole;
  logic [TERM_W-1:0]   term_a;
  mode_t               mode_nxt;
  logic                quota_hit;
  logic [SCORE_W-1:0]  score;
  logic [SCORE_W-1:0]  score_nxt;
  logic [2:0]          act_event;
  logic                breach;
  logic [2:0]          kind_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign s1_en    = !s1_v_r || adv;
  assign in_ready = s1_en;
  assign in_fire  = in_valid && s1_en;
  assign s1_fire  = adv && s1_v_r;
  assign s1_active = (s1_mode_r == MODE_ACTIVE);

  assign sample_ext = CMP_W'(in_size_sample);
  assign last_ext   = CMP_W'(last_size_r);
  assign quota_ext  = CMP_W'(quota_r);
  assign diff       = (sample_ext > last_ext) ? (sample_ext - last_ext) : (last_ext - sample_ext);
  assign whole      = (|diff[CMP_W-1:CAP_BIT]) ? WHOLE_CAP
                                                : {1'b0, diff[CAP_BIT-1:CHG_SHIFT]};
  assign term_a     = {{WHOLE_W{1'b0}}, alpha_w_r} * {{WEIGHT_W{1'b0}}, whole};
  assign quota_hit  = (quota_r != '0) && (sample_ext > quota_ext);

  always_comb begin
    if (!watching_r) begin
      mode_nxt = MODE_IDLE;
    end else if (in_size_sample == '0) begin
      mode_nxt = MODE_DETACH;
    end else begin
      mode_nxt = MODE_ACTIVE;
    end
  end

  mgam_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_fire && s1_active),
    .alpha_w   (alpha_w_r),
    .term_a    (s1_term_a_r),
    .score     (score),
    .score_nxt (score_nxt)
  );

  always_comb begin
    unique case (action_r)
      ACT_THROTTLE: act_event = EV_THROTTLE;
      ACT_KILL:     act_event = EV_KILL;
      default:      act_event = EV_ALERT;
    endcase
  end

  assign breach = s1_quota_hit_r || (score_nxt > thresh_r);

  always_comb begin
    unique case (s1_mode_r)
      MODE_ACTIVE: kind_nxt = breach ? act_event : EV_NONE;
      MODE_DETACH: kind_nxt = EV_DETACH;
      default:     kind_nxt = EV_NONE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_w_r <= ALPHA_TAB[PCT_W'(PCT_RESET)];
      thresh_r  <= '1;
      quota_r   <= '0;
      action_r  <= ACT_ALERT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA:     alpha_w_r <= ALPHA_TAB[cfg_wdata[PCT_W-1:0]];
        CFG_THRESHOLD: thresh_r  <= cfg_wdata[SCORE_W-1:0];
        CFG_QUOTA:     quota_r   <= cfg_wdata[QUOTA_W-1:0];
        CFG_ACTION:    action_r  <= cfg_wdata[1:0];
        default:       ;
      endcase
    end
  end

  // input stage and monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      watching_r  <= 1'b1;
      last_size_r <= '0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_fire;
      end
      if (in_fire) begin
        if (mode_nxt == MODE_DETACH) begin
          watching_r <= 1'b0;
        end
        if (mode_nxt == MODE_ACTIVE) begin
          last_size_r <= in_size_sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r      <= mode_nxt;
      s1_change_r    <= diff[CHANGE_W-1:0];
      s1_term_a_r    <= SCORE_W'(term_a);
      s1_quota_hit_r <= quota_hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_kind_r   <= kind_nxt;
      out_cause_r  <= s1_active && s1_quota_hit_r;
      out_score_r  <= s1_active ? score_nxt : score;
      out_change_r <= s1_active ? s1_change_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_breach_cause = out_cause_r;
  assign out_score_out    = out_score_r;
  assign out_change_out   = out_change_r;

endmodule

### src/mgam_score.sv
// EWMA score register and its Q16.16 update.
module mgam_score (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [mgam_pkg::WEIGHT_W-1:0] alpha_w,
  input  logic [mgam_pkg::SCORE_W-1:0]  term_a,
  output logic [mgam_pkg::SCORE_W-1:0]  score,
  output logic [mgam_pkg::SCORE_W-1:0]  score_nxt
);
  import mgam_pkg::*;

  localparam int PROD_W = WEIGHT_W + SCORE_W;

  logic [SCORE_W-1:0]  score_r;
  logic [WEIGHT_W-1:0] beta;
  logic [PROD_W-1:0]   prod_b;

  assign beta      = Q_UNIT - alpha_w;
  assign prod_b    = {{SCORE_W{1'b0}}, beta} * {{WEIGHT_W{1'b0}}, score_r};
  assign score_nxt = term_a + prod_b[Q_FRAC +: SCORE_W];
  assign score     = score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else if (upd) begin
      score_r <= score_nxt;
    end
  end

endmodule

### test/tb.sv
// Testbench for memory_growth_anomaly_monitor: directed table, random sample walks, then a closing table.
module tb;
  import mgam_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [47:0] SIZE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [2:0]  kind;
    logic        cause;
    logic [31:0] score;
    logic [47:0] change;
  } mon_result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [47:0] value;
    bit          typed;
    mon_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [47:0] in_size_sample;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_kind;
  logic        out_breach_cause;
  logic [31:0] out_score_out;
  logic [47:0] out_change_out;

  memory_growth_anomaly_monitor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_size_sample   (in_size_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_breach_cause (out_breach_cause),
    .out_score_out    (out_score_out),
    .out_change_out   (out_change_out)
  );

  // predictor state and register copies
  bit          mon_watching;
  logic [47:0] prev_size;
  logic [31:0] pred_score;
  logic [6:0]  reg_alpha;
  logic [31:0] reg_thresh;
  logic [47:0] reg_quota;
  logic [1:0]  reg_action;

  mon_result_t pending_results[$];
  stim_row_t   stim_tab[$];
  logic [47:0] last_sent;

  int errors;
  int n_sent;
  int n_checked;
  int n_breach;
  int n_quota;
  int n_detach;
  int stall_cnt;
  int rx_cyc;
  int rx_mode;
  int hold_left;
  bit rx_hold_req;
  bit rx_hold_seen;
  int open_end;
  int burst;
  int gap;
  int sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic mon_result_t predict_sample(logic [47:0] s);
    mon_result_t r;
    logic [63:0] pct;
    logic [63:0] w;
    logic [63:0] chg;
    logic [63:0] d;
    logic [63:0] nxt;
    logic [2:0]  ev_on_breach;
    r = '0;
    if (!mon_watching) begin
      r.kind = EV_NONE;
      r.score = pred_score;
      return r;
    end
    if (s == 48'd0) begin
      mon_watching = 1'b0;
      r.kind = EV_DETACH;
      r.score = pred_score;
      return r;
    end
    pct = (reg_alpha > PCT_FULL) ? 64'(PCT_FULL) : 64'(reg_alpha);
    w = ((64'd1 << Q_FRAC) * pct) / 64'(PCT_FULL);
    chg = (s > prev_size) ? 64'(s - prev_size) : 64'(prev_size - s);
    prev_size = s;
    r.change = chg[47:0];
    if (chg > (64'd1 << CAP_BIT)) chg = 64'd1 << CAP_BIT;
    d = ((chg >> CHG_SHIFT) << Q_FRAC) & 64'hFFFF_FFFF;
    nxt = ((w * d) >> Q_FRAC) + ((((64'd1 << Q_FRAC) - w) * 64'(pred_score)) >> Q_FRAC);
    pred_score = nxt[31:0];
    r.score = pred_score;
    case (reg_action)
      ACT_THROTTLE: ev_on_breach = EV_THROTTLE;
      ACT_KILL:     ev_on_breach = EV_KILL;
      default:      ev_on_breach = EV_ALERT;
    endcase
    if (reg_quota != 48'd0 && s > reg_quota) begin
      r.kind = ev_on_breach;
      r.cause = 1'b1;
    end else if (pred_score > reg_thresh) begin
      r.kind = ev_on_breach;
    end else begin
      r.kind = EV_NONE;
    end
    return r;
  endfunction

  function automatic logic [47:0] walk_sample(logic [47:0] base);
    logic [47:0] delta;
    logic [47:0] s;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       delta = 48'(1 << CAP_BIT) - 48'd2 + 48'($urandom_range(0, 4));
      1:       delta = 48'($urandom_range(0, 2047));
      2:       delta = 48'($urandom_range(0, 1 << 24));
      3:       delta = 48'd0;
      default: delta = 48'($urandom_range(0, 1 << 20));
    endcase
    if ($urandom_range(0, 12) == 0)
      s = {16'($urandom), 32'($urandom)};
    else if ($urandom_range(0, 1) == 1 && base > delta)
      s = base - delta;
    else
      s = base + delta;
    return (s == 48'd0) ? 48'd1 : s;
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [47:0] v);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, value: v, typed: 1'b0, res: '0};
    stim_tab.push_back(r);
  endtask

  task automatic add_smp(logic [47:0] s);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: 2'd0, value: s, typed: 1'b0, res: '0};
    stim_tab.push_back(r);
  endtask

  task automatic add_chk(logic [47:0] s, logic [2:0] k, logic c, logic [31:0] sc,
                         logic [47:0] ch);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: 2'd0, value: s, typed: 1'b1, res: '{k, c, sc, ch}};
    stim_tab.push_back(r);
  endtask

  task automatic send_sample(logic [47:0] s, bit typed, mon_result_t fixed);
    mon_result_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    in_size_sample <= s;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    r = predict_sample(s);
    pending_results.push_back(typed ? fixed : r);
    last_sent = s;
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_ALPHA:     reg_alpha = v[6:0];
      CFG_THRESHOLD: reg_thresh = v[31:0];
      CFG_QUOTA:     reg_quota = v;
      default:       reg_action = v[1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_table(int first, int last);
    for (int i = first; i < last; i++) begin
      if (stim_tab[i].is_cfg) begin
        drain();
        cfg_write(stim_tab[i].idx, stim_tab[i].value);
      end else begin
        send_sample(stim_tab[i].value, stim_tab[i].typed, stim_tab[i].res);
      end
    end
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (rx_hold_req && !rx_hold_seen) begin
        rx_hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (rx_cyc % 5 == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    mon_result_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (e.kind inside {EV_ALERT, EV_THROTTLE, EV_KILL}) n_breach++;
        if (e.cause) n_quota++;
        if (e.kind == EV_DETACH) n_detach++;
        if (out_event_kind !== e.kind) begin
          $error("event_kind: expected %0d, got %0d", e.kind, out_event_kind);
          errors++;
        end
        if (out_breach_cause !== e.cause) begin
          $error("breach_cause: expected %0d, got %0d", e.cause, out_breach_cause);
          errors++;
        end
        if (out_score_out !== e.score) begin
          $error("score_out: expected %h, got %h", e.score, out_score_out);
          errors++;
        end
        if (out_change_out !== e.change) begin
          $error("change_out: expected %h, got %h", e.change, out_change_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_size_sample = '0;
    mon_watching = 1'b1;
    prev_size = '0;
    pred_score = '0;
    reg_alpha = 7'(PCT_RESET);
    reg_thresh = '1;
    reg_quota = '0;
    reg_action = ACT_ALERT;
    last_sent = 48'd1;

    // opening table: reset values, extremes, every action, quota vs score
    add_chk(48'd1, EV_NONE, 1'b0, 32'h0000_0000, 48'd1);
    add_chk(SIZE_MAX, EV_NONE, 1'b0, 32'h1000_0000, 48'hFFFF_FFFF_FFFE);
    add_chk(SIZE_MAX, EV_NONE, 1'b0, 32'h0800_0000, 48'd0);
    add_chk(48'd1, EV_NONE, 1'b0, 32'h1400_0000, 48'hFFFF_FFFF_FFFE);
    add_cfg(CFG_THRESHOLD, 48'd0);
    add_cfg(CFG_ACTION, 48'(ACT_KILL));
    add_chk(48'd1, EV_KILL, 1'b0, 32'h0A00_0000, 48'd0);
    add_cfg(CFG_QUOTA, 48'd1000);
    add_cfg(CFG_ACTION, 48'(ACT_THROTTLE));
    add_chk(48'd1001, EV_THROTTLE, 1'b1, 32'h0500_0000, 48'd1000);
    add_chk(48'd1000, EV_THROTTLE, 1'b0, 32'h0280_0000, 48'd1);
    add_cfg(CFG_ACTION, 48'(ACT_SPARE));
    add_chk(48'd1000, EV_ALERT, 1'b0, 32'h0140_0000, 48'd0);
    add_cfg(CFG_THRESHOLD, 48'hFFFF_FFFF);
    add_cfg(CFG_QUOTA, SIZE_MAX);
    add_cfg(CFG_ALPHA, 48'd127);
    add_chk(48'd8389608, EV_NONE, 1'b0, 32'h2000_0000, 48'h80_0000);
    add_cfg(CFG_ALPHA, 48'd0);
    add_chk(48'd1, EV_NONE, 1'b0, 32'h2000_0000, 48'd8389607);
    add_cfg(CFG_ALPHA, 48'(PCT_FULL));
    add_smp(48'd8388608);
    add_smp(48'd16777217);
    add_smp(48'd16778240);
    add_smp(48'd16779264);
    add_smp(48'd16779265);
    add_cfg(CFG_ALPHA, 48'd1);
    add_cfg(CFG_QUOTA, 48'hFFFF_FFFF_FFFE);
    add_smp(SIZE_MAX);
    add_cfg(CFG_THRESHOLD, 48'h0100_0000);
    add_smp(48'hAAAA_AAAA_AAAA);
    add_smp(48'h5555_5555_5555);
    add_smp(48'h5555_5555_5556);
    open_end = stim_tab.size();

    // closing table: detach, ignored samples afterwards
    add_smp(48'd0);
    add_smp(48'd12345);
    add_smp(SIZE_MAX);
    add_smp(48'd0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_table(0, open_end);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0:       cfg_write(CFG_ALPHA, 48'd0);
        1:       cfg_write(CFG_ALPHA, 48'(PCT_FULL));
        2:       cfg_write(CFG_ALPHA, 48'd127);
        default: cfg_write(CFG_ALPHA, 48'($urandom_range(1, 99)));
      endcase
      case ($urandom_range(0, 3))
        0:       cfg_write(CFG_THRESHOLD, 48'd0);
        1:       cfg_write(CFG_THRESHOLD, 48'hFFFF_FFFF);
        default: cfg_write(CFG_THRESHOLD, 48'($urandom_range(0, 32'h2000_0000)));
      endcase
      case ($urandom_range(0, 3))
        0:       cfg_write(CFG_QUOTA, 48'd0);
        1:       cfg_write(CFG_QUOTA, SIZE_MAX);
        default: cfg_write(CFG_QUOTA, last_sent + 48'($urandom_range(0, 1 << 21))
                                      - 48'(1 << 20));
      endcase
      cfg_write(CFG_ACTION, 48'(ph % 4));

      sent = 0;
      while (sent < 180) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst; b++) begin
          send_sample(walk_sample(last_sent), 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        idle_gap(gap);
      end

      if (ph == 3) begin
        drain();
        rx_hold_req = 1'b1;
        for (int b = 0; b < 40; b++) send_sample(walk_sample(last_sent), 1'b0, '0);
      end
    end

    drain();
    run_table(open_end, stim_tab.size());
    drain();
    repeat (4) @(posedge clk);

    $display("%0d samples sent, %0d results checked over 8 register settings",
             n_sent, n_checked);
    $display("%0d breach events (%0d on quota), %0d detach", n_breach, n_quota, n_detach);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
